@@ design/lsr_pkg.sv @@
// Package for the linear stereo resampler.
// Holds the fixed-point constants, the sequencer states and the structs that pass between the
// sequencer, the shared multiply unit and the top level. It has no dependencies.
package lsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SMP_W     = 16;
  localparam int STEP_W    = 21;
  localparam int POS_W     = 22;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int MIN_STEP  = 1 << (FRAC_BITS - 5);
  localparam int MAX_RES   = 64;
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int P_W       = ((POS_W > FRAC_BITS + 1) ? POS_W : FRAC_BITS + 1) + 2;
  localparam int CMP_W     = P_W + 2;
  localparam int PROD_W    = SMP_W + 1 + FRAC_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_L,
    S_MUL_R,
    S_EMIT
  } lsr_state_t;

  typedef struct packed {
    logic              en;
    logic [SMP_W-1:0]  a;
    logic [SMP_W-1:0]  b;
    logic [FRAC_W-1:0] frac;
  } mac_req_t;

  typedef struct packed {
    logic             load;
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    logic             run_end;
    logic             stream_done;
  } out_item_t;

endpackage

@@ design/lsr_mac.sv @@
// Shared multiply unit: one registered (b - a) * frac product per request, finished into
// a + (b - a) * frac / ONE truncated toward zero and clamped to 16 bits.
// Depends on lsr_pkg.
module lsr_mac
  import lsr_pkg::*;
(
  input  logic                    clk,
  input  mac_req_t                req,
  output logic signed [SMP_W-1:0] res
);

  localparam int ACC_W = PROD_W + 1;
  localparam int QW    = ACC_W - FRAC_BITS;

  logic signed [SMP_W:0]    diff;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SMP_W-1:0]  base_r;

  function automatic logic signed [SMP_W-1:0] lerp_fin(
    input logic signed [SMP_W-1:0]  a,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W-1:0] a_x;
    logic signed [ACC_W-1:0] v;
    logic signed [QW-1:0]    q;
    logic signed [QW-1:0]    q_max;
    logic signed [QW-1:0]    q_min;
    logic                    rnd;
    a_x   = ACC_W'(a);
    v     = (a_x <<< FRAC_BITS) + ACC_W'(prod);
    rnd   = v[ACC_W-1] && (|v[FRAC_BITS-1:0]);
    q     = v[ACC_W-1:FRAC_BITS] + QW'(rnd);
    q_max = QW'(32767);
    q_min = QW'(-32768);
    if (q > q_max) begin
      q = q_max;
    end else if (q < q_min) begin
      q = q_min;
    end
    return q[SMP_W-1:0];
  endfunction

  always_comb begin
    diff     = $signed({req.b[SMP_W-1], req.b}) - $signed({req.a[SMP_W-1], req.a});
    frac_s   = $signed({1'b0, req.frac});
    prod_nxt = diff * frac_s;
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
      base_r <= $signed(req.a);
    end
  end

  assign res = lerp_fin(base_r, prod_r);

endmodule

@@ design/lsr_ctrl.sv @@
// Sequencer: holds the previous frame and output position, walks the output positions of
// one source frame and drives the shared multiply unit left then right for each result.
// Depends on lsr_pkg.
module lsr_ctrl
  import lsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SMP_W-1:0]        in_left,
  input  logic [SMP_W-1:0]        in_right,
  input  logic                    in_final,
  input  logic [STEP_W-1:0]       step,
  input  logic                    slot_free,
  input  logic signed [SMP_W-1:0] mac_res,
  output mac_req_t                req,
  output out_item_t               emit
);

  lsr_state_t        state_r, state_nxt;
  logic [SMP_W-1:0]  held_l_r, held_l_nxt;
  logic [SMP_W-1:0]  held_r_r, held_r_nxt;
  logic              have_held_r, have_held_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SMP_W-1:0]  new_l_r, new_l_nxt;
  logic [SMP_W-1:0]  new_r_r, new_r_nxt;
  logic              fin_r, fin_nxt;
  logic [STEP_W-1:0] stp_r, stp_nxt;
  logic [P_W-1:0]    p_r, p_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SMP_W-1:0]  left_res_r, left_res_nxt;
  logic [STEP_W-1:0] step_cl;
  logic [P_W-1:0]    p_adv;
  logic [CNT_W-1:0]  n_adv;
  logic [P_W-1:0]    p_fin;
  logic [FRAC_W-1:0] frac;
  logic              more;
  logic              do_finish;

  function automatic logic emit_ok(
    input logic [P_W-1:0]    p,
    input logic [CNT_W-1:0]  n,
    input logic              fin,
    input logic [STEP_W-1:0] s
  );
    logic pos_ok;
    if (fin) begin
      pos_ok = (CMP_W'({p, 1'b0}) + CMP_W'(s)) <= CMP_W'(4 * ONE);
    end else begin
      pos_ok = p < P_W'(ONE);
    end
    return (n < CNT_W'(MAX_RES)) && pos_ok;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_held_r <= 1'b0;
      pos_r       <= '0;
      held_l_r    <= '0;
      held_r_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      have_held_r <= have_held_nxt;
      pos_r       <= pos_nxt;
      held_l_r    <= held_l_nxt;
      held_r_r    <= held_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_l_r    <= new_l_nxt;
    new_r_r    <= new_r_nxt;
    fin_r      <= fin_nxt;
    stp_r      <= stp_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    left_res_r <= left_res_nxt;
  end

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign step_cl  = (step < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : step;
  assign p_adv    = p_r + P_W'(stp_r);
  assign n_adv    = n_r + CNT_W'(1);
  assign more     = emit_ok(p_adv, n_adv, fin_r, stp_r);
  assign frac     = (p_r >= P_W'(ONE)) ? FRAC_W'(ONE) : FRAC_W'(p_r[FRAC_BITS-1:0]);

  always_comb begin
    state_nxt     = state_r;
    new_l_nxt     = new_l_r;
    new_r_nxt     = new_r_r;
    fin_nxt       = fin_r;
    stp_nxt       = stp_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    left_res_nxt  = left_res_r;
    held_l_nxt    = held_l_r;
    held_r_nxt    = held_r_r;
    have_held_nxt = have_held_r;
    pos_nxt       = pos_r;
    do_finish     = 1'b0;
    p_fin         = p_r;
    req           = '0;
    emit          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_l_nxt = in_left;
          new_r_nxt = in_right;
          fin_nxt   = in_final;
          stp_nxt   = step_cl;
          p_nxt     = have_held_r ? P_W'(pos_r) : P_W'(pos_r) + P_W'(ONE);
          n_nxt     = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (emit_ok(p_r, n_r, fin_r, stp_r)) begin
          state_nxt = S_MUL_L;
        end else begin
          do_finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MUL_L: begin
        req.en    = 1'b1;
        req.a     = held_l_r;
        req.b     = new_l_r;
        req.frac  = frac;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        req.en       = 1'b1;
        req.a        = held_r_r;
        req.b        = new_r_r;
        req.frac     = frac;
        left_res_nxt = mac_res;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit.load        = 1'b1;
          emit.left        = left_res_r;
          emit.right       = mac_res;
          emit.run_end     = !more;
          emit.stream_done = fin_r && !more;
          p_nxt            = p_adv;
          n_nxt            = n_adv;
          p_fin            = p_adv;
          if (more) begin
            state_nxt = S_MUL_L;
          end else begin
            do_finish = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_finish) begin
      if (fin_r) begin
        held_l_nxt    = '0;
        held_r_nxt    = '0;
        have_held_nxt = 1'b0;
        pos_nxt       = '0;
      end else begin
        held_l_nxt    = new_l_r;
        held_r_nxt    = new_r_r;
        have_held_nxt = 1'b1;
        pos_nxt       = (p_fin >= P_W'(ONE)) ? POS_W'(p_fin - P_W'(ONE)) : '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (n_r <= CNT_W'(MAX_RES)))
    else $error("result count past limit");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_EVAL))
    else $error("accepted frame not evaluated");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.load && emit.stream_done) |=> (!have_held_r && pos_r == '0 && state_r == S_IDLE))
    else $error("state not cleared after stream end");

  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !have_held_r |-> (pos_r == '0))
    else $error("position set with no held frame");

endmodule

@@ design/linear_stereo_resampler_core.sv @@
// Linear stereo resampler, top level: phase step register, sequencer, shared multiply unit
// and the output register. Depends on lsr_pkg, lsr_ctrl and lsr_mac.
//
// Usage: one stereo source frame is transferred on in_* (valid/stall); the block emits
// zero to 64 interpolated frames on out_* (valid/stall), with out_run_end on the last frame
// caused by that source frame and out_stream_done on the last frame of the stream.
// cfg_phase_step (source rate / target rate, Q5.16) is written over cfg_valid/cfg_ready;
// the block leaves it to the user to write it only while the block is idle.
// Values below 1/32 act as 1/32. Per source frame the sequencer takes an evaluation step,
// then per result a left and a right pass through the single shared multiplier and a step
// to load the output register, then returns to idle, where in_stall drops. in_stall stays
// high throughout the frame.
// A stalled receiver holds the output register and pauses the sequencer in its load step.
// Reset (synchronous, active low) clears the held frame, position and output valid and
// sets the phase step to 1.0; at that step frames pass through delayed by one frame.
module linear_stereo_resampler_core
  import lsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SMP_W-1:0]  in_left_in,
  input  logic [SMP_W-1:0]  in_right_in,
  input  logic              in_final_frame,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SMP_W-1:0]  out_left_out,
  output logic [SMP_W-1:0]  out_right_out,
  output logic              out_run_end,
  output logic              out_stream_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_phase_step
);

  logic [STEP_W-1:0]       step_r;
  logic                    out_valid_r;
  logic [SMP_W-1:0]        out_left_r;
  logic [SMP_W-1:0]        out_right_r;
  logic                    out_run_end_r;
  logic                    out_done_r;
  logic                    slot_free;
  logic signed [SMP_W-1:0] mac_res;
  mac_req_t                req;
  out_item_t               emit;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_W'(ONE);
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_left_r    <= emit.left;
      out_right_r   <= emit.right;
      out_run_end_r <= emit.run_end;
      out_done_r    <= emit.stream_done;
    end
  end

  lsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_left   (in_left_in),
    .in_right  (in_right_in),
    .in_final  (in_final_frame),
    .step      (step_r),
    .slot_free (slot_free),
    .mac_res   (mac_res),
    .req       (req),
    .emit      (emit)
  );

  lsr_mac u_mac (
    .clk (clk),
    .req (req),
    .res (mac_res)
  );

  assign out_valid       = out_valid_r;
  assign out_left_out    = out_left_r;
  assign out_right_out   = out_right_r;
  assign out_run_end     = out_run_end_r;
  assign out_stream_done = out_done_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> slot_free)
    else $error("output register overwritten while stalled");

  a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_run_end_r)
    else $error("stream end without run end");

endmodule
